@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hw/rtl/efwd_pkg.sv @@
// Shared constants and types for the earliest-free-worker dispatcher.
package efwd_pkg;

  localparam int TIME_W          = 64;
  localparam int DUR_W           = 32;
  localparam int CFG_W           = 5;
  localparam int WORKER_W        = 4;
  localparam int MAX_WORKERS_DEF = 16;
  localparam int COUNT_RESET     = 16;

  typedef struct packed {
    logic insert;
    logic sort;
    logic phase;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/earliest_free_worker_dispatch.sv @@
// The result is registered at the accept edge; out_valid rises in the next cycle. A new job is
// taken only after the last one's add at the chain head and reinsert shift in ST_INSERT.
// A worker_count write resorts the cell chain by odd-even exchange, with in_ready low.
// Reset (rst, synchronous): all free times zero, worker_count COUNT_RESET capped at
// MAX_WORKERS, chain ordered by worker index.
`include "assert_macros.svh"

module earliest_free_worker_dispatch #(
  parameter int MAX_WORKERS = efwd_pkg::MAX_WORKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efwd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [efwd_pkg::DUR_W-1:0]    duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efwd_pkg::WORKER_W-1:0] worker,
  output logic [efwd_pkg::TIME_W-1:0]  start_time
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int N_RST = (efwd_pkg::COUNT_RESET < MAX_WORKERS) ?
                         efwd_pkg::COUNT_RESET : MAX_WORKERS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_SORT   = 2'd2;

  logic [1:0]                 state;
  logic [CNT_W-1:0]           n_eff;
  logic [CNT_W-1:0]           n_eff_next;
  logic [CNT_W-1:0]           sort_cnt;
  logic [efwd_pkg::TIME_W-1:0] pend_time;
  logic [IDX_W-1:0]           pend_idx;
  logic [efwd_pkg::TIME_W:0]  sum_wide;
  logic                       in_acc;
  logic                       cfg_acc;
  efwd_pkg::cell_ctrl_t       ctrl;

  logic [efwd_pkg::TIME_W-1:0] c_time [MAX_WORKERS];
  logic [IDX_W-1:0]           c_idx  [MAX_WORKERS];
  logic                       c_act  [MAX_WORKERS];
  logic                       c_lt   [MAX_WORKERS];

  // a request accepted this cycle holds off the config write
  assign cfg_ready = (state != ST_INSERT) && !in_acc;
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign ctrl.insert = (state == ST_INSERT);
  assign ctrl.sort   = (state == ST_SORT);
  assign ctrl.phase  = sort_cnt[0];

  assign sum_wide = {1'b0, c_time[0]} + (efwd_pkg::TIME_W + 1)'(duration);

  always_comb begin
    if (cfg_data == '0) begin
      n_eff_next = CNT_W'(1);
    end else if (32'(cfg_data) > MAX_WORKERS) begin
      n_eff_next = CNT_W'(MAX_WORKERS);
    end else begin
      n_eff_next = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n_eff     <= CNT_W'(N_RST);
      sort_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_acc) begin
        n_eff    <= n_eff_next;
        sort_cnt <= '0;
        state    <= ST_SORT;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (in_acc) begin
              state <= ST_INSERT;
            end
          end
          ST_INSERT: state <= ST_IDLE;
          ST_SORT: begin
            if (sort_cnt == CNT_W'(MAX_WORKERS - 1)) begin
              state <= ST_IDLE;
            end else begin
              sort_cnt <= sort_cnt + CNT_W'(1);
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      worker     <= efwd_pkg::WORKER_W'(c_idx[0]);
      start_time <= c_time[0];
      pend_idx   <= c_idx[0];
      pend_time  <= sum_wide[efwd_pkg::TIME_W] ? '1 : sum_wide[efwd_pkg::TIME_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    logic [efwd_pkg::TIME_W-1:0] l_time;
    logic [IDX_W-1:0]           l_idx;
    logic                       l_act;
    logic [efwd_pkg::TIME_W-1:0] r_time;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_act;
    logic                       r_lt;

    if (i > 0) begin : g_left
      assign l_time = c_time[i-1];
      assign l_idx  = c_idx[i-1];
      assign l_act  = c_act[i-1];
    end else begin : g_left_edge
      assign l_time = c_time[i];
      assign l_idx  = c_idx[i];
      assign l_act  = c_act[i];
    end

    if (i < MAX_WORKERS - 1) begin : g_right
      assign r_time = c_time[i+1];
      assign r_idx  = c_idx[i+1];
      assign r_act  = c_act[i+1];
      assign r_lt   = c_lt[i+1];
    end else begin : g_right_edge
      assign r_time = c_time[i];
      assign r_idx  = c_idx[i];
      assign r_act  = c_act[i];
      assign r_lt   = 1'b0;
    end

    efwd_cell #(
      .INDEX (i),
      .COUNT (MAX_WORKERS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .n_eff        (n_eff),
      .new_time     (pend_time),
      .new_idx      (pend_idx),
      .left_time    (l_time),
      .left_idx     (l_idx),
      .left_act     (l_act),
      .right_time   (r_time),
      .right_idx    (r_idx),
      .right_act    (r_act),
      .right_lt_new (r_lt),
      .ftime        (c_time[i]),
      .idx          (c_idx[i]),
      .act          (c_act[i]),
      .lt_new       (c_lt[i])
    );
  end

  `ASSERT_NEXT(a_accept_inserts, in_valid && in_ready, state == ST_INSERT)
  `ASSERT_IMPL(a_head_active, state == ST_IDLE, c_act[0])
  `ASSERT_IMPL(a_out_from_accept, $rose(out_valid), $past(in_valid && in_ready))
  `ASSERT_NEXT(a_cfg_resorts, cfg_valid && cfg_ready, state == ST_SORT && sort_cnt == '0)

endmodule

@@ hw/rtl/efwd_cell.sv @@
// One cell of the sorted worker chain: holds a worker's index and free time.
module efwd_cell #(
  parameter int INDEX = 0,
  parameter int COUNT = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  efwd_pkg::cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]           n_eff,
  input  logic [efwd_pkg::TIME_W-1:0] new_time,
  input  logic [IDX_W-1:0]           new_idx,
  input  logic [efwd_pkg::TIME_W-1:0] left_time,
  input  logic [IDX_W-1:0]           left_idx,
  input  logic                       left_act,
  input  logic [efwd_pkg::TIME_W-1:0] right_time,
  input  logic [IDX_W-1:0]           right_idx,
  input  logic                       right_act,
  input  logic                       right_lt_new,
  output logic [efwd_pkg::TIME_W-1:0] ftime,
  output logic [IDX_W-1:0]           idx,
  output logic                       act,
  output logic                       lt_new
);

  localparam bit HAS_LEFT  = INDEX > 0;
  localparam bit HAS_RIGHT = INDEX < COUNT - 1;
  localparam bit PAR       = (INDEX % 2) == 1;

  logic self_lt_new;
  logic right_lt_self;
  logic self_lt_left;
  logic pair_right;
  logic pair_left;

  // key order: active first, then free time, then index
  function automatic logic key_lt(
    input logic a_act, input logic [efwd_pkg::TIME_W-1:0] a_time, input logic [IDX_W-1:0] a_idx,
    input logic b_act, input logic [efwd_pkg::TIME_W-1:0] b_time, input logic [IDX_W-1:0] b_idx
  );
    logic r;
    if (a_act != b_act) begin
      r = a_act;
    end else if (a_time != b_time) begin
      r = a_time < b_time;
    end else begin
      r = a_idx < b_idx;
    end
    return r;
  endfunction

  assign act           = CNT_W'(idx) < n_eff;
  assign self_lt_new   = key_lt(act, ftime, idx, 1'b1, new_time, new_idx);
  assign right_lt_self = key_lt(right_act, right_time, right_idx, act, ftime, idx);
  assign self_lt_left  = key_lt(act, ftime, idx, left_act, left_time, left_idx);
  assign pair_right    = HAS_RIGHT && (ctrl.phase == PAR);
  assign pair_left     = HAS_LEFT && (ctrl.phase != PAR);
  // head is the entry being reinserted, so it always yields
  assign lt_new        = (INDEX == 0) ? 1'b1 : self_lt_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      ftime <= '0;
      idx   <= IDX_W'(INDEX);
    end else begin
      if (ctrl.insert) begin
        if (right_lt_new) begin
          ftime <= right_time;
          idx   <= right_idx;
        end else if (lt_new) begin
          ftime <= new_time;
          idx   <= new_idx;
        end
      end else if (ctrl.sort) begin
        if (pair_right && right_lt_self) begin
          ftime <= right_time;
          idx   <= right_idx;
        end else if (pair_left && self_lt_left) begin
          ftime <= left_time;
          idx   <= left_idx;
        end
      end
    end
  end

endmodule
